// ----- src/egtl_pkg.sv -----
package egtl_pkg;

	// field widths fixed by the item formats
	localparam int TEMP_W    = 12;
	localparam int TEMP_INPUTS = 6;
	localparam int MASK_W    = 6;
	localparam int RPM_W     = 16;
	localparam int TICK_W    = 10;
	localparam int PCT_W     = 7;
	localparam int RETARD_W  = 14;
	localparam int LAMBDA_W  = 17;
	localparam int MS_W      = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;

	// divider sizing: quotient is below 100, numerator is a 16-bit rpm offset times 100
	localparam int DIV_NUM_W = 23;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_Q_W   = 7;
	localparam int DIV_SHIFT = DIV_Q_W - 1;
	localparam int DIV_CNT_W = 3;

	// comparison thresholds, degrees Celsius, in a widened signed domain
	localparam int CMP_W = 14;
	localparam logic signed [CMP_W-1:0] FAULT_LO  = -14'sd50;
	localparam logic signed [CMP_W-1:0] FAULT_HI  = 14'sd1500;
	localparam logic signed [CMP_W-1:0] HYST_BAND = 14'sd50;
	localparam logic signed [CMP_W-1:0] CUT_BAND  = 14'sd100;

	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
	localparam logic [PCT_W-1:0] PCT_ZERO = 7'd0;

	typedef logic signed [TEMP_W-1:0] temp_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE    = 3'd0,
		REG_MAX_TEMP  = 3'd1,
		REG_DELAY     = 3'd2,
		REG_START_RPM = 3'd3,
		REG_RPM_SPAN  = 3'd4,
		REG_BAND_TWO  = 3'd5,
		REG_MAX_RET   = 3'd6,
		REG_MAX_LAM   = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_UPDATE,
		ST_DIV,
		ST_MULT,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] numer;
		logic [DIV_DEN_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_Q_W-1:0] quot;
	} div_stat_t;

endpackage

// ----- src/egtl_sample_if.sv -----
interface egtl_sample_if;
	logic                              valid;
	logic                              ready;
	egtl_pkg::temp_t                   temp_one;
	egtl_pkg::temp_t                   temp_two;
	egtl_pkg::temp_t                   temp_three;
	egtl_pkg::temp_t                   temp_four;
	egtl_pkg::temp_t                   temp_five;
	egtl_pkg::temp_t                   temp_six;
	logic [egtl_pkg::MASK_W-1:0]       valid_mask;
	logic [egtl_pkg::RPM_W-1:0]        engine_rpm;
	logic [egtl_pkg::TICK_W-1:0]       tick_ms;

	modport source (
		output valid, temp_one, temp_two, temp_three, temp_four, temp_five, temp_six,
		output valid_mask, engine_rpm, tick_ms,
		input  ready
	);

	modport sink (
		input  valid, temp_one, temp_two, temp_three, temp_four, temp_five, temp_six,
		input  valid_mask, engine_rpm, tick_ms,
		output ready
	);
endinterface

// ----- src/egtl_result_if.sv -----
interface egtl_result_if;
	logic                                valid;
	logic                                ready;
	egtl_pkg::temp_t                     egt_used;
	logic                                limiting_active;
	logic                                sensor_fault;
	logic [egtl_pkg::PCT_W-1:0]          limit_pct;
	logic [egtl_pkg::PCT_W-1:0]          throttle_pct;
	logic signed [egtl_pkg::RETARD_W-1:0] retard_centideg;
	logic [egtl_pkg::LAMBDA_W-1:0]       lambda_cut_scaled;
	logic [egtl_pkg::MS_W-1:0]           over_limit_ms;

	modport source (
		output valid, egt_used, limiting_active, sensor_fault, limit_pct, throttle_pct,
		output retard_centideg, lambda_cut_scaled, over_limit_ms,
		input  ready
	);

	modport sink (
		input  valid, egt_used, limiting_active, sensor_fault, limit_pct, throttle_pct,
		input  retard_centideg, lambda_cut_scaled, over_limit_ms,
		output ready
	);
endinterface

// ----- src/egtl_cfg_if.sv -----
interface egtl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [egtl_pkg::CFG_IDX_W-1:0]    index;
	logic [egtl_pkg::CFG_DAT_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/egtl_div.sv -----
module egtl_div (
	input  logic                clk,
	input  logic                arst_n,
	input  egtl_pkg::div_req_t  req,
	output egtl_pkg::div_stat_t stat
);

	localparam int DSH_W = egtl_pkg::DIV_DEN_W + egtl_pkg::DIV_SHIFT;
	localparam logic [egtl_pkg::DIV_CNT_W-1:0] LAST_STEP =
		egtl_pkg::DIV_CNT_W'(egtl_pkg::DIV_Q_W - 1);

	logic [egtl_pkg::DIV_NUM_W-1:0] rem_q;
	logic [DSH_W-1:0]               dsh_q;
	logic [egtl_pkg::DIV_Q_W-1:0]   quot_q;
	logic [egtl_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic                           fits;
	logic [egtl_pkg::DIV_NUM_W-1:0] dsh_ext;

	// one restoring step: compare against the shifted divisor and subtract
	assign dsh_ext = egtl_pkg::DIV_NUM_W'(dsh_q);
	assign fits    = rem_q >= dsh_ext;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.numer;
			dsh_q  <= {req.denom, {egtl_pkg::DIV_SHIFT{1'b0}}};
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_ext;
			end
			quot_q <= {quot_q[egtl_pkg::DIV_Q_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign stat = '{busy: busy_q, done: done_q, quot: quot_q};

endmodule

// ----- src/egt_overheat_limiter.sv -----
// Exhaust gas temperature overheat limiter. Each sample transfer carries six
// exhaust readings with a valid mask, engine rpm and elapsed milliseconds; each
// one yields exactly one result transfer. The block is not ready while a sample
// is in work: a sample passes a serial scan of SENSOR_COUNT (at most six)
// sensors, the select, update and scaling steps, a hand-off to the output
// register, and, when the rpm lies inside the ramp band, the serial restoring
// divider that forms the limit percent. A new sample is taken only after the
// last one is handed off; the hand-off stretches while an earlier result waits.
// The output register lets the next sample be taken while a result still waits.
// Configuration writes are taken at any cycle and must be made only while no
// sample is in work.
module egt_overheat_limiter #(
	parameter int SENSOR_COUNT = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	egtl_sample_if.sink          sample,
	egtl_result_if.source        result,
	egtl_cfg_if.sink             cfg
);

	localparam int SCAN_N = (SENSOR_COUNT < egtl_pkg::TEMP_INPUTS) ?
		SENSOR_COUNT : egtl_pkg::TEMP_INPUTS;
	localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;
	localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(SCAN_N - 1);

	// configuration registers
	logic                              en_q;
	logic [10:0]                       max_temp_q;
	logic [15:0]                       delay_q;
	logic [egtl_pkg::RPM_W-1:0]        start_q;
	logic [egtl_pkg::RPM_W-1:0]        span_q;
	logic [egtl_pkg::PCT_W-1:0]        band_q;
	logic [5:0]                        maxret_q;
	logic [9:0]                        maxlam_q;

	// limiter state
	logic                              active_q;
	logic [egtl_pkg::PCT_W-1:0]        pct_q;
	logic                              run_q;
	logic [egtl_pkg::MS_W-1:0]         tmr_q;
	logic [egtl_pkg::MS_W-1:0]         over_q;
	logic [egtl_pkg::PCT_W-1:0]        thr_q;
	logic signed [egtl_pkg::RETARD_W-1:0] retard_q;
	logic [egtl_pkg::LAMBDA_W-1:0]     lambda_q;
	logic                              fault_q;
	logic                              mult_en_q;

	// sample latch and scan
	egtl_pkg::temp_t                   temps_in [egtl_pkg::TEMP_INPUTS];
	egtl_pkg::temp_t                   temp_q [SCAN_N];
	logic [SCAN_N-1:0]                 mask_q;
	logic [egtl_pkg::RPM_W-1:0]        rpm_q;
	logic [egtl_pkg::TICK_W-1:0]       tick_q;
	logic [IDX_W-1:0]                  scan_q;
	egtl_pkg::temp_t                   best_q;
	egtl_pkg::temp_t                   egt_q;
	logic                              scan_last;
	logic                              scan_take;
	logic                              first_ok;

	// output register
	logic                              res_valid_q;
	egtl_pkg::temp_t                   res_egt_q;
	logic                              res_act_q;
	logic                              res_fault_q;
	logic [egtl_pkg::PCT_W-1:0]        res_pct_q;
	logic [egtl_pkg::PCT_W-1:0]        res_thr_q;
	logic signed [egtl_pkg::RETARD_W-1:0] res_retard_q;
	logic [egtl_pkg::LAMBDA_W-1:0]     res_lambda_q;
	logic [egtl_pkg::MS_W-1:0]         res_over_q;

	// sequencer
	egtl_pkg::seq_state_t              state_q;
	egtl_pkg::seq_state_t              state_n;
	logic                              slot_free;
	logic                              take_sample;
	logic                              out_load;
	logic                              upd_en;

	// divider
	egtl_pkg::div_req_t                div_req;
	egtl_pkg::div_stat_t               div_st;

	// update step results
	logic signed [egtl_pkg::CMP_W-1:0] egt_x;
	logic signed [egtl_pkg::CMP_W-1:0] lim_x;
	logic                              upd_fault;
	logic                              exceeded;
	logic [egtl_pkg::MS_W:0]           tmr_sum;
	logic [egtl_pkg::MS_W:0]           over_sum;
	logic [egtl_pkg::MS_W-1:0]         tmr_inc;
	logic [egtl_pkg::MS_W-1:0]         over_inc;
	logic                              run_n;
	logic [egtl_pkg::MS_W-1:0]         tmr_n;
	logic                              act_n;
	logic [egtl_pkg::PCT_W-1:0]        pct_n;
	logic [egtl_pkg::MS_W-1:0]         over_n;
	logic [egtl_pkg::PCT_W-1:0]        thr_n;
	logic                              upd_div;
	logic [egtl_pkg::RPM_W:0]          rpm_end;
	logic [egtl_pkg::RPM_W-1:0]        rpm_diff;
	logic [egtl_pkg::DIV_NUM_W-1:0]    diff_ext;
	logic [12:0]                       prod_ret;
	logic [egtl_pkg::LAMBDA_W-1:0]     prod_lam;

	// configuration port
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q       <= 1'b0;
			max_temp_q <= 11'd950;
			delay_q    <= 16'd0;
			start_q    <= 16'd0;
			span_q     <= 16'd1000;
			band_q     <= 7'd50;
			maxret_q   <= 6'd0;
			maxlam_q   <= 10'd0;
		end else if (cfg.valid) begin
			case (egtl_pkg::cfg_reg_t'(cfg.index))
				egtl_pkg::REG_ENABLE:    en_q       <= cfg.data[0];
				egtl_pkg::REG_MAX_TEMP:  max_temp_q <= cfg.data[10:0];
				egtl_pkg::REG_DELAY:     delay_q    <= cfg.data;
				egtl_pkg::REG_START_RPM: start_q    <= cfg.data;
				egtl_pkg::REG_RPM_SPAN:  span_q     <= cfg.data;
				egtl_pkg::REG_BAND_TWO:  band_q     <= cfg.data[6:0];
				egtl_pkg::REG_MAX_RET:   maxret_q   <= cfg.data[5:0];
				egtl_pkg::REG_MAX_LAM:   maxlam_q   <= cfg.data[9:0];
				default: ;
			endcase
		end
	end

	// sequencer next state
	assign slot_free = !res_valid_q || result.ready;
	assign scan_last = scan_q == SCAN_LAST;

	always_comb begin
		state_n = state_q;
		case (state_q)
			egtl_pkg::ST_IDLE:   if (sample.valid) state_n = egtl_pkg::ST_SCAN;
			egtl_pkg::ST_SCAN:   if (scan_last) state_n = egtl_pkg::ST_PICK;
			egtl_pkg::ST_PICK:   state_n = egtl_pkg::ST_UPDATE;
			egtl_pkg::ST_UPDATE: state_n = upd_div ? egtl_pkg::ST_DIV : egtl_pkg::ST_MULT;
			egtl_pkg::ST_DIV:    if (div_st.done) state_n = egtl_pkg::ST_MULT;
			egtl_pkg::ST_MULT:   state_n = egtl_pkg::ST_OUT;
			egtl_pkg::ST_OUT:    if (slot_free) state_n = egtl_pkg::ST_IDLE;
			default:             state_n = egtl_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample.ready  = 1'b0;
		upd_en        = 1'b0;
		out_load      = 1'b0;
		div_req.start = 1'b0;
		// divider operands: rpm offset times 100 over the span
		div_req.numer = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
		div_req.denom = span_q;
		case (state_q)
			egtl_pkg::ST_IDLE:   sample.ready = 1'b1;
			egtl_pkg::ST_UPDATE: begin
				upd_en        = 1'b1;
				div_req.start = upd_div;
			end
			egtl_pkg::ST_OUT:    out_load = slot_free;
			default: ;
		endcase
	end

	assign take_sample = sample.valid && sample.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= egtl_pkg::ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// sample latch
	assign temps_in[0] = sample.temp_one;
	assign temps_in[1] = sample.temp_two;
	assign temps_in[2] = sample.temp_three;
	assign temps_in[3] = sample.temp_four;
	assign temps_in[4] = sample.temp_five;
	assign temps_in[5] = sample.temp_six;

	always_ff @(posedge clk) begin
		if (take_sample) begin
			for (int i = 0; i < SCAN_N; i++) begin
				temp_q[i] <= temps_in[i];
			end
			mask_q <= sample.valid_mask[SCAN_N-1:0];
			rpm_q  <= sample.engine_rpm;
			tick_q <= sample.tick_ms;
		end
	end

	// serial scan for the hottest valid positive reading, one sensor a cycle
	assign scan_take = mask_q[scan_q] && (temp_q[scan_q] > best_q);
	assign first_ok  = mask_q[0] && (temp_q[0] > 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
		end else if (take_sample) begin
			scan_q <= '0;
		end else if (state_q == egtl_pkg::ST_SCAN && !scan_last) begin
			scan_q <= scan_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_sample) begin
			best_q <= '0;
		end else if (state_q == egtl_pkg::ST_SCAN && scan_take) begin
			best_q <= temp_q[scan_q];
		end
		if (state_q == egtl_pkg::ST_PICK) begin
			egt_q <= first_ok ? temp_q[0] : best_q;
		end
	end

	// limiter update: fault check, delay timer, bands and percent selection
	assign egt_x    = egtl_pkg::CMP_W'(egt_q);
	assign lim_x    = $signed({3'b000, max_temp_q});
	assign tmr_sum  = {1'b0, tmr_q} + (egtl_pkg::MS_W + 1)'(tick_q);
	assign over_sum = {1'b0, over_q} + (egtl_pkg::MS_W + 1)'(tick_q);
	assign tmr_inc  = tmr_sum[egtl_pkg::MS_W] ? '1 : tmr_sum[egtl_pkg::MS_W-1:0];
	assign over_inc = over_sum[egtl_pkg::MS_W] ? '1 : over_sum[egtl_pkg::MS_W-1:0];
	assign rpm_end  = {1'b0, start_q} + {1'b0, span_q};
	assign rpm_diff = rpm_q - start_q;
	assign diff_ext = egtl_pkg::DIV_NUM_W'(rpm_diff);

	always_comb begin
		upd_fault = 1'b0;
		exceeded  = egt_x > lim_x;
		run_n     = run_q;
		tmr_n     = tmr_q;
		act_n     = active_q;
		pct_n     = pct_q;
		over_n    = over_q;
		thr_n     = thr_q;
		upd_div   = 1'b0;
		if (!en_q) begin
			act_n  = 1'b0;
			pct_n  = egtl_pkg::PCT_ZERO;
			over_n = '0;
			thr_n  = egtl_pkg::PCT_FULL;
		end else if (egt_x < egtl_pkg::FAULT_LO || egt_x > egtl_pkg::FAULT_HI) begin
			upd_fault = 1'b1;
			thr_n     = egtl_pkg::PCT_ZERO;
			pct_n     = egtl_pkg::PCT_FULL;
			act_n     = 1'b1;
		end else begin
			// delay timer starts at the first exceedance
			if (exceeded && !run_q) begin
				run_n = 1'b1;
				tmr_n = '0;
			end else if (run_q) begin
				tmr_n = tmr_inc;
			end
			act_n = exceeded && (tmr_n >= egtl_pkg::MS_W'(delay_q));
			pct_n = egtl_pkg::PCT_ZERO;
			if (act_n) begin
				if (rpm_q < start_q) begin
					pct_n = egtl_pkg::PCT_ZERO;
				end else if ({1'b0, rpm_q} >= rpm_end) begin
					pct_n = egtl_pkg::PCT_FULL;
				end else begin
					upd_div = 1'b1;
				end
				over_n = over_inc;
			end
			// release below the hysteresis band
			if (egt_x < lim_x - egtl_pkg::HYST_BAND) begin
				run_n   = 1'b0;
				tmr_n   = '0;
				act_n   = 1'b0;
				pct_n   = egtl_pkg::PCT_ZERO;
				upd_div = 1'b0;
			end
			// throttle bands, held between the two cut bands
			if (egt_x <= lim_x) begin
				thr_n = egtl_pkg::PCT_FULL;
			end else if (egt_x <= lim_x + egtl_pkg::HYST_BAND) begin
				thr_n = band_q;
			end else if (egt_x > lim_x + egtl_pkg::CUT_BAND) begin
				thr_n = egtl_pkg::PCT_ZERO;
			end
		end
	end

	// retard and lambda scaling by the limit percent
	assign prod_ret = {6'b0, pct_q} * {7'b0, maxret_q};
	assign prod_lam = {10'b0, pct_q} * {7'b0, maxlam_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			pct_q     <= egtl_pkg::PCT_ZERO;
			run_q     <= 1'b0;
			tmr_q     <= '0;
			over_q    <= '0;
			thr_q     <= egtl_pkg::PCT_FULL;
			retard_q  <= '0;
			lambda_q  <= '0;
			fault_q   <= 1'b0;
			mult_en_q <= 1'b0;
		end else begin
			if (upd_en) begin
				active_q  <= act_n;
				pct_q     <= pct_n;
				run_q     <= run_n;
				tmr_q     <= tmr_n;
				over_q    <= over_n;
				thr_q     <= thr_n;
				fault_q   <= upd_fault;
				mult_en_q <= en_q && !upd_fault;
				if (!en_q) begin
					retard_q <= '0;
					lambda_q <= '0;
				end
			end
			if (state_q == egtl_pkg::ST_DIV && div_st.done) begin
				pct_q <= div_st.quot;
			end
			if (state_q == egtl_pkg::ST_MULT && mult_en_q) begin
				retard_q <= -$signed({1'b0, prod_ret});
				lambda_q <= prod_lam;
			end
		end
	end

	egtl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.stat   (div_st)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_egt_q    <= egt_q;
			res_act_q    <= active_q;
			res_fault_q  <= fault_q;
			res_pct_q    <= pct_q;
			res_thr_q    <= thr_q;
			res_retard_q <= retard_q;
			res_lambda_q <= lambda_q;
			res_over_q   <= over_q;
		end
	end

	assign result.valid             = res_valid_q;
	assign result.egt_used          = res_egt_q;
	assign result.limiting_active   = res_act_q;
	assign result.sensor_fault      = res_fault_q;
	assign result.limit_pct         = res_pct_q;
	assign result.throttle_pct      = res_thr_q;
	assign result.retard_centideg   = res_retard_q;
	assign result.lambda_cut_scaled = res_lambda_q;
	assign result.over_limit_ms     = res_over_q;

	// checks
	a_ready_not_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		sample.ready |-> !div_st.busy)
		else $error("sample ready while divider busy");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == egtl_pkg::ST_DIV)
		else $error("divider finished outside divide step");

	a_fault_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.sensor_fault) |->
		(result.limit_pct == egtl_pkg::PCT_FULL && result.throttle_pct == egtl_pkg::PCT_ZERO
		&& result.limiting_active))
		else $error("fault result without emergency outputs");

endmodule
